FILE: rtl/core/crcr_pkg.sv
// shared constants, register indexes and bit-reversal helpers for the crc16 block
`timescale 1ns / 1ps

package crcr_pkg;

    localparam int CRC_W  = 16;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 2;

    localparam logic [CRC_W-1:0] POLY_RESET  = 16'h1021;
    localparam logic [CRC_W-1:0] INIT_RESET  = 16'hFFFF;
    localparam logic [CRC_W-1:0] FXOR_RESET  = 16'hFFFF;

    typedef enum logic [IDX_W-1:0] {
        CFG_POLYNOMIAL    = 2'd0,
        CFG_INITIAL_VALUE = 2'd1,
        CFG_FINAL_XOR     = 2'd2
    } t_cfg_index;

    typedef logic [CRC_W-1:0]  t_crc;
    typedef logic [BYTE_W-1:0] t_byte;

    function automatic t_byte mirror8(input t_byte v);
        t_byte r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    function automatic t_crc mirror16(input t_crc v);
        t_crc r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/crcr_fold.sv
// eight unrolled division steps folding one reflected byte into the remainder
`timescale 1ns / 1ps

module crcr_fold (
    input  crcr_pkg::t_crc  i_remainder,
    input  crcr_pkg::t_byte i_data_byte,
    input  crcr_pkg::t_crc  i_polynomial,
    input  crcr_pkg::t_crc  i_final_xor,
    output crcr_pkg::t_crc  o_remainder,
    output crcr_pkg::t_crc  o_crc_value
);

    crcr_pkg::t_crc rem;

    always_comb begin
        rem = i_remainder ^ {crcr_pkg::mirror8(i_data_byte), {crcr_pkg::BYTE_W{1'b0}}};
        for (int k = 0; k < crcr_pkg::BYTE_W; k++) begin
            if (rem[crcr_pkg::CRC_W-1]) begin
                rem = {rem[crcr_pkg::CRC_W-2:0], 1'b0} ^ i_polynomial;
            end else begin
                rem = {rem[crcr_pkg::CRC_W-2:0], 1'b0};
            end
        end
    end

    assign o_remainder = rem;
    assign o_crc_value = crcr_pkg::mirror16(rem) ^ i_final_xor;

endmodule

FILE: rtl/core/crc16_reflected_configurable.sv
// a byte is registered in the input register on accept and folded from there; the crc word
// of a last byte is written to the result register when that byte leaves the input register
// throughput: one byte per clock, set by the eight-step fold between the input register
// and the remainder/result registers; stall rises only while a last byte waits on a
// result word that has not been taken
// reset (synchronous, active low): registers take their default values, pipeline empties
`timescale 1ns / 1ps

module crc16_reflected_configurable (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // message bytes
    input  logic                         i_valid,
    output logic                         o_stall,
    input  crcr_pkg::t_byte              i_data_byte,
    input  logic                         i_first_of_message,
    input  logic                         i_last_of_message,
    // crc words
    output logic                         o_valid,
    input  logic                         i_stall,
    output crcr_pkg::t_crc               o_crc_value,
    // register writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [crcr_pkg::IDX_W-1:0]   i_cfg_index,
    input  crcr_pkg::t_crc               i_cfg_data
);

    crcr_pkg::t_crc  r_polynomial, r_initial_value, r_final_xor;
    crcr_pkg::t_crc  r_rem;
    logic            r_s1_valid, r_s1_first, r_s1_last;
    crcr_pkg::t_byte r_s1_byte;
    logic            r_out_valid;
    crcr_pkg::t_crc  r_out_crc;

    crcr_pkg::t_crc  fold_base, fold_rem, fold_crc;
    logic            out_blocked, advance, in_accept;

    assign out_blocked = r_out_valid && i_stall;
    assign advance     = r_s1_valid && !(r_s1_last && out_blocked);
    assign o_stall     = r_s1_valid && !advance;
    assign in_accept   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_crc_value = r_out_crc;

    assign fold_base = r_s1_first ? r_initial_value : r_rem;

    crcr_fold u_fold (
        .i_remainder  (fold_base),
        .i_data_byte  (r_s1_byte),
        .i_polynomial (r_polynomial),
        .i_final_xor  (r_final_xor),
        .o_remainder  (fold_rem),
        .o_crc_value  (fold_crc)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polynomial    <= crcr_pkg::POLY_RESET;
            r_initial_value <= crcr_pkg::INIT_RESET;
            r_final_xor     <= crcr_pkg::FXOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                crcr_pkg::CFG_POLYNOMIAL:    r_polynomial    <= i_cfg_data;
                crcr_pkg::CFG_INITIAL_VALUE: r_initial_value <= i_cfg_data;
                crcr_pkg::CFG_FINAL_XOR:     r_final_xor     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte  <= i_data_byte;
            r_s1_first <= i_first_of_message;
            r_s1_last  <= i_last_of_message;
        end
    end

    // running remainder, reloaded after a last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= crcr_pkg::INIT_RESET;
        end else if (advance) begin
            r_rem <= r_s1_last ? r_initial_value : fold_rem;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_last) begin
            r_out_crc <= fold_crc;
        end
    end

    // a waiting last byte is never dropped
    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_last && out_blocked |=> r_s1_valid)
        else $error("last byte lost while result word stalled");

    // a new result word only follows a folded last byte
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && r_s1_last))
        else $error("result word without a last byte");

    // remainder reloads with the start value after a message ends
    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_s1_last |=> r_rem == $past(r_initial_value))
        else $error("remainder not reloaded after last byte");

    // stall only with a last byte waiting in the input register behind a valid result word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && r_s1_last && r_out_valid)
        else $error("stall without a blocked last byte");

endmodule
